// ===== design/tno_pkg.sv =====
// Package for the telnet option negotiator: option table sizing, supported-mask
// reset values and telnet verb codes. No dependencies.
`default_nettype none

package tno_pkg;

	localparam int NUM_OPTIONS = 256;
	localparam int OPT_W       = 8;
	localparam int OPT_IDX_W   = (NUM_OPTIONS > 1) ? $clog2(NUM_OPTIONS) : 1;

	localparam int SUP_WORDS   = 4;
	localparam int SUP_WORD_W  = 64;
	localparam int CFG_IDX_W   = 2;

	localparam logic [SUP_WORD_W-1:0] SUP_RESET_0 = 64'd549806145538;
	localparam logic [SUP_WORD_W-1:0] SUP_RESET_1 = 64'd64;
	localparam logic [SUP_WORD_W-1:0] SUP_RESET_2 = 64'd0;
	localparam logic [SUP_WORD_W-1:0] SUP_RESET_3 = 64'd0;

	localparam logic [7:0] VERB_NONE = 8'd0;
	localparam logic [7:0] VERB_WILL = 8'd251;
	localparam logic [7:0] VERB_WONT = 8'd252;
	localparam logic [7:0] VERB_DO   = 8'd253;
	localparam logic [7:0] VERB_DONT = 8'd254;

endpackage

`default_nettype wire

// ===== design/telnet_option_negotiator.sv =====
// Telnet option negotiator top level: flag memory, supported mask, one input
// stage and one result stage. Depends on tno_pkg.
// Accepted transactions pass the input stage, then the result stage (out_valid).
// Throughput: one transaction per cycle; a held result stalls the input stage.
// Reset: the supported mask returns to its default and both stages empty; then a clearing
// pass zeroes all NUM_OPTIONS (256) flag memory entries while in_stall stays high.
`default_nettype none

module telnet_option_negotiator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              command,
	input  wire logic                              side,
	input  wire logic                              enable,
	input  wire logic [tno_pkg::OPT_W-1:0]         option,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   send_valid,
	output logic [7:0]                             send_verb,
	output logic [tno_pkg::OPT_W-1:0]              send_option,
	output logic                                   now_enabled,
	output logic                                   enabled_changed,
	output logic                                   notify,
	input  wire logic                              cfg_we,
	input  wire logic [tno_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tno_pkg::SUP_WORD_W-1:0]    cfg_data
);

	// flag word: {peer_req, peer_en, loc_req, loc_en}
	logic [tno_pkg::SUP_WORD_W-1:0] sup_q [tno_pkg::SUP_WORDS];
	logic [3:0]                     flag_mem [tno_pkg::NUM_OPTIONS];
	logic                           clearing_q;
	logic [tno_pkg::OPT_IDX_W-1:0]  clr_idx_q;

	logic                        valid_s1, command_s1, side_s1, enable_s1;
	logic [tno_pkg::OPT_W-1:0]   option_s1;
	logic [3:0]                  flags_s1;

	logic                        valid_s2, send_valid_s2, now_enabled_s2;
	logic                        enabled_changed_s2, notify_s2;
	logic [7:0]                  send_verb_s2;
	logic [tno_pkg::OPT_W-1:0]   send_option_s2;

	logic                          advance, load_s1, in_range, sup, old_en, old_req;
	logic                          new_en, new_req, send, ntf, wr_flags;
	logic [7:0]                    verb;
	logic [3:0]                    wr_word;
	logic [tno_pkg::OPT_IDX_W-1:0] idx, rd_idx;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = clearing_q || (valid_s1 && !advance);
	assign load_s1  = !in_stall;

	assign in_range = ({1'b0, option_s1} < (tno_pkg::OPT_W+1)'(tno_pkg::NUM_OPTIONS));
	assign idx      = option_s1[tno_pkg::OPT_IDX_W-1:0];
	assign rd_idx   = option[tno_pkg::OPT_IDX_W-1:0];
	assign sup      = sup_q[option_s1[7:6]][option_s1[5:0]];
	assign old_en   = side_s1 ? flags_s1[2] : flags_s1[0];
	assign old_req  = side_s1 ? flags_s1[3] : flags_s1[1];
	assign wr_flags = advance && valid_s1 && in_range;
	assign wr_word  = side_s1 ? {new_req, new_en, flags_s1[1:0]}
		: {flags_s1[3:2], new_req, new_en};

	always_comb begin
		new_en  = old_en;
		new_req = old_req;
		send    = 1'b0;
		verb    = tno_pkg::VERB_NONE;
		ntf     = 1'b0;
		if (!command_s1) begin
			ntf     = 1'b1;
			new_req = 1'b0;
			if (enable_s1) begin
				new_en = sup;
				send   = !old_req && !old_en;
				if (side_s1)
					verb = sup ? tno_pkg::VERB_DO : tno_pkg::VERB_DONT;
				else
					verb = sup ? tno_pkg::VERB_WILL : tno_pkg::VERB_WONT;
			end else begin
				new_en = 1'b0;
				send   = !old_req && old_en;
				verb   = side_s1 ? tno_pkg::VERB_DONT : tno_pkg::VERB_WONT;
			end
		end else begin
			if ((old_en != enable_s1) && !old_req) begin
				send    = 1'b1;
				new_req = 1'b1;
			end
			if (side_s1)
				verb = enable_s1 ? tno_pkg::VERB_DO : tno_pkg::VERB_DONT;
			else
				verb = enable_s1 ? tno_pkg::VERB_WILL : tno_pkg::VERB_WONT;
		end
		if (!in_range) begin
			send   = 1'b0;
			ntf    = 1'b0;
			new_en = old_en;
		end
		if (!send)
			verb = tno_pkg::VERB_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sup_q[0] <= tno_pkg::SUP_RESET_0;
			sup_q[1] <= tno_pkg::SUP_RESET_1;
			sup_q[2] <= tno_pkg::SUP_RESET_2;
			sup_q[3] <= tno_pkg::SUP_RESET_3;
		end else if (cfg_we) begin
			sup_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + (tno_pkg::OPT_IDX_W)'(1);
			if (clr_idx_q == (tno_pkg::OPT_IDX_W)'(tno_pkg::NUM_OPTIONS - 1))
				clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q)
			flag_mem[clr_idx_q] <= '0;
		else if (wr_flags)
			flag_mem[idx] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && load_s1) begin
			command_s1 <= command;
			side_s1    <= side;
			enable_s1  <= enable;
			option_s1  <= option;
			flags_s1   <= (wr_flags && (rd_idx == idx)) ? wr_word : flag_mem[rd_idx];
		end
		if (advance && valid_s1) begin
			send_valid_s2      <= send;
			send_verb_s2       <= verb;
			send_option_s2     <= send ? option_s1 : '0;
			now_enabled_s2     <= in_range ? new_en : 1'b0;
			enabled_changed_s2 <= in_range && (new_en != old_en);
			notify_s2          <= ntf;
		end
	end

	assign out_valid       = valid_s2;
	assign send_valid      = send_valid_s2;
	assign send_verb       = send_verb_s2;
	assign send_option     = send_option_s2;
	assign now_enabled     = now_enabled_s2;
	assign enabled_changed = enabled_changed_s2;
	assign notify          = notify_s2;

	a_no_send_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send_valid |-> send_verb == tno_pkg::VERB_NONE && send_option == '0)
		else $error("reply bytes set without a reply");

	a_verb_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_valid |-> send_verb == tno_pkg::VERB_WILL ||
			send_verb == tno_pkg::VERB_WONT || send_verb == tno_pkg::VERB_DO ||
			send_verb == tno_pkg::VERB_DONT)
		else $error("reply with an unknown verb");

	a_local_keeps_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !notify |-> !enabled_changed)
		else $error("local request changed the enabled flag");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && out_stall |=> valid_s1 && $stable(option_s1))
		else $error("input stage lost a waiting transaction");

endmodule

`default_nettype wire

// ===== tb/tb_telnet_option_negotiator.sv =====
`timescale 1ns / 1ps
// Testbench for telnet_option_negotiator: directed table plus phased random negotiation
// traffic, checked against an in-bench flag-table predictor. Depends on tno_pkg and the RTL.

module tb_telnet_option_negotiator;

	typedef enum logic {CMD_RECEIVED = 1'b0, CMD_LOCAL = 1'b1} cmd_t;
	typedef enum logic {SIDE_OURS = 1'b0, SIDE_PEER = 1'b1} side_t;
	typedef enum logic [tno_pkg::CFG_IDX_W-1:0] {
		REG_SUPPORTED_0, REG_SUPPORTED_1, REG_SUPPORTED_2, REG_SUPPORTED_3
	} reg_t;

	typedef struct packed {
		logic                      send_valid;
		logic [7:0]                send_verb;
		logic [tno_pkg::OPT_W-1:0] send_option;
		logic                      now_enabled;
		logic                      enabled_changed;
		logic                      notify;
	} reply_t;

	typedef struct packed {
		cmd_t                      command;
		side_t                     side;
		logic                      enable;
		logic [tno_pkg::OPT_W-1:0] option;
		logic                      typed;
		reply_t                    reply;
	} negotiation_t;

	localparam int PHASE_ITEMS = 166;
	localparam int HOLD_CYCLES = 80;
	localparam int MAX_PRINTS = 50;

	localparam logic [7:0] V_NONE = tno_pkg::VERB_NONE;
	localparam logic [7:0] V_WILL = tno_pkg::VERB_WILL;
	localparam logic [7:0] V_WONT = tno_pkg::VERB_WONT;
	localparam logic [7:0] V_DO   = tno_pkg::VERB_DO;
	localparam logic [7:0] V_DONT = tno_pkg::VERB_DONT;

	localparam negotiation_t DIRECTED [0:23] = '{
		'{CMD_RECEIVED, SIDE_OURS, 1'b1, 8'd1,   1'b1, '{1'b1, V_WILL, 8'd1,   1'b1, 1'b1, 1'b1}},
		'{CMD_RECEIVED, SIDE_OURS, 1'b1, 8'd1,   1'b1, '{1'b0, V_NONE, 8'd0,   1'b1, 1'b0, 1'b1}},
		'{CMD_RECEIVED, SIDE_OURS, 1'b0, 8'd1,   1'b1, '{1'b1, V_WONT, 8'd1,   1'b0, 1'b1, 1'b1}},
		'{CMD_RECEIVED, SIDE_PEER, 1'b1, 8'd0,   1'b1, '{1'b1, V_DONT, 8'd0,   1'b0, 1'b0, 1'b1}},
		'{CMD_RECEIVED, SIDE_PEER, 1'b1, 8'd255, 1'b1, '{1'b1, V_DONT, 8'd255, 1'b0, 1'b0, 1'b1}},
		'{CMD_RECEIVED, SIDE_PEER, 1'b1, 8'd70,  1'b1, '{1'b1, V_DO,   8'd70,  1'b1, 1'b1, 1'b1}},
		'{CMD_RECEIVED, SIDE_PEER, 1'b0, 8'd200, 1'b1, '{1'b0, V_NONE, 8'd0,   1'b0, 1'b0, 1'b1}},
		'{CMD_LOCAL,    SIDE_OURS, 1'b1, 8'd24,  1'b1, '{1'b1, V_WILL, 8'd24,  1'b0, 1'b0, 1'b0}},
		'{CMD_LOCAL,    SIDE_OURS, 1'b1, 8'd24,  1'b1, '{1'b0, V_NONE, 8'd0,   1'b0, 1'b0, 1'b0}},
		'{CMD_RECEIVED, SIDE_OURS, 1'b1, 8'd24,  1'b1, '{1'b0, V_NONE, 8'd0,   1'b1, 1'b1, 1'b1}},
		'{CMD_LOCAL,    SIDE_OURS, 1'b1, 8'd24,  1'b1, '{1'b0, V_NONE, 8'd0,   1'b1, 1'b0, 1'b0}},
		'{CMD_LOCAL,    SIDE_OURS, 1'b0, 8'd24,  1'b1, '{1'b1, V_WONT, 8'd24,  1'b1, 1'b0, 1'b0}},
		'{CMD_RECEIVED, SIDE_OURS, 1'b0, 8'd24,  1'b1, '{1'b0, V_NONE, 8'd0,   1'b0, 1'b1, 1'b1}},
		'{CMD_LOCAL,    SIDE_PEER, 1'b1, 8'd255, 1'b1, '{1'b1, V_DO,   8'd255, 1'b0, 1'b0, 1'b0}},
		'{CMD_RECEIVED, SIDE_PEER, 1'b1, 8'd255, 1'b1, '{1'b0, V_NONE, 8'd0,   1'b0, 1'b0, 1'b1}},
		'{CMD_LOCAL,    SIDE_PEER, 1'b0, 8'd0,   1'b1, '{1'b0, V_NONE, 8'd0,   1'b0, 1'b0, 1'b0}},
		'{CMD_LOCAL,    SIDE_PEER, 1'b1, 8'd39,  1'b1, '{1'b1, V_DO,   8'd39,  1'b0, 1'b0, 1'b0}},
		'{CMD_RECEIVED, SIDE_PEER, 1'b0, 8'd39,  1'b1, '{1'b0, V_NONE, 8'd0,   1'b0, 1'b0, 1'b1}},
		'{CMD_RECEIVED, SIDE_PEER, 1'b0, 8'd70,  1'b1, '{1'b1, V_DONT, 8'd70,  1'b0, 1'b1, 1'b1}},
		'{CMD_RECEIVED, SIDE_OURS, 1'b1, 8'd0,   1'b1, '{1'b1, V_WONT, 8'd0,   1'b0, 1'b0, 1'b1}},
		'{CMD_LOCAL,    SIDE_PEER, 1'b1, 8'd63,  1'b0, '0},
		'{CMD_LOCAL,    SIDE_OURS, 1'b1, 8'd64,  1'b0, '0},
		'{CMD_RECEIVED, SIDE_OURS, 1'b1, 8'd191, 1'b0, '0},
		'{CMD_RECEIVED, SIDE_PEER, 1'b1, 8'd192, 1'b0, '0}
	};

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic                           command = 1'b0;
	logic                           side = 1'b0;
	logic                           enable = 1'b0;
	logic [tno_pkg::OPT_W-1:0]      option = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic                           send_valid;
	logic [7:0]                     send_verb;
	logic [tno_pkg::OPT_W-1:0]      send_option;
	logic                           now_enabled;
	logic                           enabled_changed;
	logic                           notify;
	logic                           cfg_we = 1'b0;
	logic [tno_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tno_pkg::SUP_WORD_W-1:0] cfg_data = '0;

	bit [tno_pkg::NUM_OPTIONS-1:0]  our_on, our_pending, peer_on, peer_pending;
	bit [tno_pkg::SUP_WORD_W-1:0]   supported_mask [tno_pkg::SUP_WORDS] =
		'{tno_pkg::SUP_RESET_0, tno_pkg::SUP_RESET_1, tno_pkg::SUP_RESET_2,
			tno_pkg::SUP_RESET_3};

	negotiation_t pending_messages [$];
	reply_t       replies_due [$];
	negotiation_t offered;
	reply_t       predicted;
	int           n_queued = 0;
	int           n_checked = 0;
	int           n_errors = 0;
	bit           calm = 1'b0;
	bit           pressure_go = 1'b0;
	bit           pressure_done = 1'b0;
	int           hold_left = 0;

	telnet_option_negotiator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .side(side), .enable(enable), .option(option),
		.out_valid(out_valid), .out_stall(out_stall),
		.send_valid(send_valid), .send_verb(send_verb), .send_option(send_option),
		.now_enabled(now_enabled), .enabled_changed(enabled_changed), .notify(notify),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic reply_t negotiate_reply(input negotiation_t m);
		reply_t r;
		bit was_on, on, pend, sup;
		r = '0;
		was_on = (m.side == SIDE_PEER) ? peer_on[m.option] : our_on[m.option];
		pend = (m.side == SIDE_PEER) ? peer_pending[m.option] : our_pending[m.option];
		sup = supported_mask[m.option[7:6]][m.option[5:0]];
		on = was_on;
		if (m.command == CMD_RECEIVED) begin
			r.notify = 1'b1;
			if (m.enable) begin
				on = sup;
				if (pend) begin
					pend = 1'b0;
				end else if (!was_on) begin
					r.send_valid = 1'b1;
					if (m.side == SIDE_PEER)
						r.send_verb = sup ? V_DO : V_DONT;
					else
						r.send_verb = sup ? V_WILL : V_WONT;
				end
			end else begin
				on = 1'b0;
				if (pend) begin
					pend = 1'b0;
				end else if (was_on) begin
					r.send_valid = 1'b1;
					r.send_verb = (m.side == SIDE_PEER) ? V_DONT : V_WONT;
				end
			end
		end else if (was_on != m.enable && !pend) begin
			r.send_valid = 1'b1;
			if (m.side == SIDE_PEER)
				r.send_verb = m.enable ? V_DO : V_DONT;
			else
				r.send_verb = m.enable ? V_WILL : V_WONT;
			pend = 1'b1;
		end
		if (r.send_valid)
			r.send_option = m.option;
		r.now_enabled = on;
		r.enabled_changed = (on != was_on);
		if (m.side == SIDE_PEER) begin
			peer_on[m.option] = on;
			peer_pending[m.option] = pend;
		end else begin
			our_on[m.option] = on;
			our_pending[m.option] = pend;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic queue_item(input negotiation_t m);
		pending_messages.push_back(m);
		n_queued++;
	endtask

	task automatic queue_random(input int count);
		logic [tno_pkg::OPT_W-1:0] pool [8];
		int made;
		int roll;
		logic en;
		negotiation_t m;
		made = 0;
		foreach (pool[i])
			pool[i] = tno_pkg::OPT_W'($urandom_range(255));
		while (made < count) begin
			roll = $urandom_range(99);
			m = '0;
			m.side = side_t'($urandom_range(1));
			en = 1'($urandom_range(1));
			m.enable = en;
			if ($urandom_range(3) == 0)
				m.option = tno_pkg::OPT_W'($urandom_range(255));
			else
				m.option = pool[$urandom_range(7)];
			if (roll < 45) begin
				// request, then the partner's answer, sometimes a refusal
				m.command = CMD_LOCAL;
				queue_item(m);
				m.command = CMD_RECEIVED;
				if ($urandom_range(3) == 0)
					m.enable = ~en;
				queue_item(m);
				made += 2;
			end else if (roll < 75) begin
				m.command = CMD_RECEIVED;
				queue_item(m);
				made++;
				if ($urandom_range(1)) begin
					m.enable = 1'($urandom_range(1));
					queue_item(m);
					made++;
				end
			end else begin
				m.command = cmd_t'($urandom_range(1));
				queue_item(m);
				made++;
			end
		end
	endtask

	task automatic write_supported(input reg_t which,
		input logic [tno_pkg::SUP_WORD_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		supported_mask[which] = value;
	endtask

	task automatic set_mask(input logic [tno_pkg::SUP_WORD_W-1:0] w0, w1, w2, w3);
		write_supported(REG_SUPPORTED_0, w0);
		write_supported(REG_SUPPORTED_1, w1);
		write_supported(REG_SUPPORTED_2, w2);
		write_supported(REG_SUPPORTED_3, w3);
	endtask

	task automatic wait_drained();
		while (n_checked != n_queued)
			@(posedge clk);
	endtask

	// sender: advance on acceptance, hold payload while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= 1'b0;
			side <= 1'b0;
			enable <= 1'b0;
			option <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predicted = negotiate_reply(offered);
				replies_due.push_back(offered.typed ? offered.reply : predicted);
			end
			if (!in_valid || !in_stall) begin
				if (pending_messages.size() > 0 && (calm || $urandom_range(99) >= 37)) begin
					offered = pending_messages.pop_front();
					in_valid <= 1'b1;
					command <= offered.command;
					side <= offered.side;
					enable <= offered.enable;
					option <= offered.option;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (pressure_go && !pressure_done) begin
			pressure_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 37);
		end
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				report_mismatch($sformatf("reply with nothing expected: verb %0d option %0d",
					send_verb, send_option));
			end else begin
				want = replies_due.pop_front();
				n_checked++;
				if (send_valid !== want.send_valid)
					report_mismatch($sformatf("send_valid want %0d got %0d",
						want.send_valid, send_valid));
				if (send_verb !== want.send_verb)
					report_mismatch($sformatf("send_verb want %0d got %0d",
						want.send_verb, send_verb));
				if (send_option !== want.send_option)
					report_mismatch($sformatf("send_option want %0d got %0d",
						want.send_option, send_option));
				if (now_enabled !== want.now_enabled)
					report_mismatch($sformatf("now_enabled want %0d got %0d",
						want.now_enabled, now_enabled));
				if (enabled_changed !== want.enabled_changed)
					report_mismatch($sformatf("enabled_changed want %0d got %0d",
						want.enabled_changed, enabled_changed));
				if (notify !== want.notify)
					report_mismatch($sformatf("notify want %0d got %0d",
						want.notify, notify));
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		foreach (DIRECTED[i])
			queue_item(DIRECTED[i]);
		queue_random(PHASE_ITEMS);
		wait_drained();
		for (int phase = 1; phase < 8; phase++) begin
			case (phase)
				1: set_mask('1, '1, '1, '1);
				2: set_mask('0, '0, '0, '0);
				5: set_mask({32{2'b10}}, {32{2'b01}}, {32{2'b10}}, {32{2'b01}});
				7: set_mask(tno_pkg::SUP_RESET_0, tno_pkg::SUP_RESET_1,
					tno_pkg::SUP_RESET_2, tno_pkg::SUP_RESET_3);
				default: set_mask({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom});
			endcase
			calm = (phase == 3);
			if (phase == 3)
				pressure_go = 1'b1;
			queue_random(PHASE_ITEMS);
			wait_drained();
		end
		repeat (4) @(posedge clk);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
